[src/error_detection_code_checker_macros.svh]
// ----------------------------------------------------------------------------
// Error detection code checker - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ERROR_DETECTION_CODE_CHECKER_MACROS_SVH
`define ERROR_DETECTION_CODE_CHECKER_MACROS_SVH

// same-cycle implication, masked during reset
`define EDCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define EDCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, active during reset
`define EDCC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/edcc_pkg.sv]
// ----------------------------------------------------------------------------
// Error detection code checker - package
// Widths, polynomials, pipeline word type and CRC byte-update functions.
// ----------------------------------------------------------------------------
package edcc_pkg;

  localparam int WordBits = 64;
  localparam int ByteBits = 8;
  localparam int NumBytes = WordBits / ByteBits;
  localparam int SumBits  = 11;

  localparam logic [7:0]  Crc8Poly  = 8'h31;
  localparam logic [15:0] Crc16Poly = 16'h1021;

  // word carried down the byte pipeline; _e fields are computed on the
  // error pattern (CRC and parity are linear) or on the corrupted word (sum)
  typedef struct packed {
    logic [WordBits-1:0] data_word;
    logic [WordBits-1:0] error_pattern;
    logic [7:0]          crc8_d;
    logic [7:0]          crc8_e;
    logic [15:0]         crc16_d;
    logic [15:0]         crc16_e;
    logic [SumBits-1:0]  sum_d;
    logic [SumBits-1:0]  sum_e;
    logic [7:0]          col_d;
    logic [7:0]          col_e;
    logic [7:0]          row_d;
    logic [7:0]          row_e;
  } stage_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0};
      if (fb) r = r ^ Crc8Poly;
    end
    return r;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ Crc16Poly;
    end
    return r;
  endfunction

endpackage

[src/edcc_in_if.sv]
// ----------------------------------------------------------------------------
// Error detection code checker - input channel
// Valid/ready channel carrying the data word and the error pattern.
// ----------------------------------------------------------------------------
interface edcc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [63:0] error_pattern;

  modport source (output valid, output data_word, output error_pattern, input ready);
  modport sink   (input valid, input data_word, input error_pattern, output ready);
endinterface

[src/edcc_out_if.sv]
// ----------------------------------------------------------------------------
// Error detection code checker - output channel
// Valid/ready channel carrying check codes and pass flags.
// ----------------------------------------------------------------------------
interface edcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] crc8_value;
  logic [15:0] crc16_value;
  logic [7:0] checksum_value;
  logic [7:0] column_parity;
  logic [8:0] row_parity;
  logic       crc8_pass;
  logic       crc16_pass;
  logic       checksum_pass;
  logic       parity_pass;

  modport source (output valid, output crc8_value, output crc16_value,
                  output checksum_value, output column_parity, output row_parity,
                  output crc8_pass, output crc16_pass, output checksum_pass,
                  output parity_pass, input ready);
  modport sink   (input valid, input crc8_value, input crc16_value,
                  input checksum_value, input column_parity, input row_parity,
                  input crc8_pass, input crc16_pass, input checksum_pass,
                  input parity_pass, output ready);
endinterface

[src/edcc_byte_stage.sv]
// ----------------------------------------------------------------------------
// Error detection code checker - byte stage
// Folds one byte of the word into the CRC, sum and parity accumulators.
// ----------------------------------------------------------------------------
module edcc_byte_stage #(
  parameter int ByteIdx = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  edcc_pkg::stage_t in_st,
  output logic             out_valid,
  input  logic             out_ready,
  output edcc_pkg::stage_t out_st
);

  localparam int Hi     = edcc_pkg::WordBits - 1 - edcc_pkg::ByteBits * ByteIdx;
  localparam int RowBit = edcc_pkg::NumBytes - 1 - ByteIdx;
  localparam int PadBits = edcc_pkg::SumBits - edcc_pkg::ByteBits;

  logic [edcc_pkg::ByteBits-1:0] db;
  logic [edcc_pkg::ByteBits-1:0] eb;
  logic [edcc_pkg::ByteBits-1:0] cb;
  edcc_pkg::stage_t              st_next;

  assign db = in_st.data_word[Hi -: edcc_pkg::ByteBits];
  assign eb = in_st.error_pattern[Hi -: edcc_pkg::ByteBits];
  assign cb = db ^ eb;

  always_comb begin
    st_next         = in_st;
    st_next.crc8_d  = edcc_pkg::crc8_byte(in_st.crc8_d, db);
    st_next.crc8_e  = edcc_pkg::crc8_byte(in_st.crc8_e, eb);
    st_next.crc16_d = edcc_pkg::crc16_byte(in_st.crc16_d, db);
    st_next.crc16_e = edcc_pkg::crc16_byte(in_st.crc16_e, eb);
    st_next.sum_d   = in_st.sum_d + {{PadBits{1'b0}}, db};
    st_next.sum_e   = in_st.sum_e + {{PadBits{1'b0}}, cb};
    st_next.col_d   = in_st.col_d ^ db;
    st_next.col_e   = in_st.col_e ^ eb;
    st_next.row_d[RowBit] = ^db;
    st_next.row_e[RowBit] = ^eb;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_st <= st_next;
    end
  end

endmodule

[src/edcc_finish.sv]
// ----------------------------------------------------------------------------
// Error detection code checker - finish stage
// End-around carry fold, complement, pass flags and output register.
// ----------------------------------------------------------------------------
module edcc_finish (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  edcc_pkg::stage_t in_st,
  edcc_out_if.source       egress
);

  function automatic logic [7:0] fold_cmp(input logic [edcc_pkg::SumBits-1:0] s);
    logic [8:0] s1;
    logic [7:0] s2;
    s1 = {6'd0, s[edcc_pkg::SumBits-1:8]} + {1'b0, s[7:0]};
    s2 = s1[8] ? (s1[7:0] + 8'd1) : s1[7:0];
    return ~s2;
  endfunction

  logic [7:0] cs_d;
  logic [7:0] cs_e;

  assign cs_d     = fold_cmp(in_st.sum_d);
  assign cs_e     = fold_cmp(in_st.sum_e);
  assign in_ready = !egress.valid || egress.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      egress.valid <= 1'b0;
    end else if (in_ready) begin
      egress.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      egress.crc8_value     <= in_st.crc8_d;
      egress.crc16_value    <= in_st.crc16_d;
      egress.checksum_value <= cs_d;
      egress.column_parity  <= in_st.col_d;
      egress.row_parity     <= {^in_st.col_d, in_st.row_d};
      egress.crc8_pass      <= (in_st.crc8_e == 8'd0);
      egress.crc16_pass     <= (in_st.crc16_e == 16'd0);
      egress.checksum_pass  <= (cs_e == cs_d);
      egress.parity_pass    <= (in_st.col_e == 8'd0) && (in_st.row_e == 8'd0);
    end
  end

endmodule

[src/error_detection_code_checker.sv]
// ----------------------------------------------------------------------------
// Error detection code checker - top level
// CRC-8, CRC-16, folded checksum and 2D parity on a 64-bit word, with
// pass flags for the word XOR an error pattern.
//
//   channel   dir   payload
//   ingress   in    data_word, error_pattern
//   egress    out   crc8..crc16 values, checksum, parities, four pass flags
//
// Eight byte stages, then the fold/compare output stage.
// One word per cycle sustained; each stage holds when its successor is full
// and stalled, so ready ripples back through the nine stage registers.
// Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module error_detection_code_checker (
  input  logic      clk,
  input  logic      rst,
  edcc_in_if.sink   ingress,
  edcc_out_if.source egress
);

  edcc_pkg::stage_t st    [0:edcc_pkg::NumBytes];
  logic             vld   [0:edcc_pkg::NumBytes];
  logic             rdy   [0:edcc_pkg::NumBytes];

  always_comb begin
    st[0]               = '0;
    st[0].data_word     = ingress.data_word;
    st[0].error_pattern = ingress.error_pattern;
  end

  assign vld[0]        = ingress.valid;
  assign ingress.ready = rdy[0];

  for (genvar k = 0; k < edcc_pkg::NumBytes; k++) begin : g_byte
    edcc_byte_stage #(.ByteIdx(k)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_st     (st[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_st    (st[k+1])
    );
  end

  edcc_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[edcc_pkg::NumBytes]),
    .in_ready (rdy[edcc_pkg::NumBytes]),
    .in_st    (st[edcc_pkg::NumBytes]),
    .egress   (egress)
  );

endmodule

[src/edcc_checker.sv]
// ----------------------------------------------------------------------------
// Error detection code checker - port checker
// Assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "error_detection_code_checker_macros.svh"

module edcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  crc8_value,
  input logic [15:0] crc16_value,
  input logic [7:0]  checksum_value,
  input logic [7:0]  column_parity,
  input logic [8:0]  row_parity,
  input logic [3:0]  pass_flags
);

  `EDCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(crc8_value) && $stable(crc16_value) && $stable(checksum_value) && $stable(row_parity) && $stable(pass_flags), "stalled output word changed")
  `EDCC_ASSERT_NOW(a_row_col, out_valid, row_parity[8] == ^column_parity, "row parity bit 8 disagrees with column parity")
  `EDCC_ASSERT_NOW(a_ready_flow, out_ready, in_ready, "input not ready while output drains")
  `EDCC_ASSERT_RST(a_rst_clear, rst, !out_valid, "output word valid after reset")

endmodule

bind error_detection_code_checker edcc_checker u_edcc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (ingress.ready),
  .out_valid      (egress.valid),
  .out_ready      (egress.ready),
  .crc8_value     (egress.crc8_value),
  .crc16_value    (egress.crc16_value),
  .checksum_value (egress.checksum_value),
  .column_parity  (egress.column_parity),
  .row_parity     (egress.row_parity),
  .pass_flags     ({egress.crc8_pass, egress.crc16_pass, egress.checksum_pass,
                    egress.parity_pass})
);
